[hdl/slt_pkg.sv]
//------------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the script language tokenizer.
//------------------------------------------------------------------------------
package slt_pkg;

   localparam int unsigned KIND_BITS   = 5;
   localparam int unsigned DETAIL_BITS = 3;
   localparam int unsigned OUT_OFS     = 24;
   localparam int unsigned OUT_CNT     = 16;

   localparam logic [4:0] K_ID      = 5'd0;
   localparam logic [4:0] K_NUMBER  = 5'd1;
   localparam logic [4:0] K_STRING  = 5'd2;
   localparam logic [4:0] K_VAR     = 5'd3;
   localparam logic [4:0] K_NIL     = 5'd4;
   localparam logic [4:0] K_IF      = 5'd5;
   localparam logic [4:0] K_ELSE    = 5'd6;
   localparam logic [4:0] K_FUNC    = 5'd7;
   localparam logic [4:0] K_RETURN  = 5'd8;
   localparam logic [4:0] K_FOR     = 5'd9;
   localparam logic [4:0] K_WHILE   = 5'd10;
   localparam logic [4:0] K_ANDOR   = 5'd11;
   localparam logic [4:0] K_NOT     = 5'd12;
   localparam logic [4:0] K_ADDSUB  = 5'd13;
   localparam logic [4:0] K_MULDIV  = 5'd14;
   localparam logic [4:0] K_MOD     = 5'd15;
   localparam logic [4:0] K_POW     = 5'd16;
   localparam logic [4:0] K_LBRACE  = 5'd17;
   localparam logic [4:0] K_RBRACE  = 5'd18;
   localparam logic [4:0] K_LPAREN  = 5'd19;
   localparam logic [4:0] K_RPAREN  = 5'd20;
   localparam logic [4:0] K_LBRACK  = 5'd21;
   localparam logic [4:0] K_RBRACK  = 5'd22;
   localparam logic [4:0] K_STATEND = 5'd23;
   localparam logic [4:0] K_COMMA   = 5'd24;
   localparam logic [4:0] K_ASSIGN  = 5'd25;
   localparam logic [4:0] K_DOT     = 5'd26;
   localparam logic [4:0] K_CMP     = 5'd27;
   localparam logic [4:0] K_INCLUDE = 5'd28;
   localparam logic [4:0] K_ERROR   = 5'd29;

   localparam logic [2:0] E_UNKNOWN    = 3'd0;
   localparam logic [2:0] E_BANG       = 3'd1;
   localparam logic [2:0] E_NO_QUOTE   = 3'd2;
   localparam logic [2:0] E_INCL_OPEN  = 3'd3;
   localparam logic [2:0] E_STR_OPEN   = 3'd4;

   localparam logic [2:0] C_EQ = 3'd0;
   localparam logic [2:0] C_NE = 3'd1;
   localparam logic [2:0] C_LT = 3'd2;
   localparam logic [2:0] C_LE = 3'd3;
   localparam logic [2:0] C_GT = 3'd4;
   localparam logic [2:0] C_GE = 3'd5;

   typedef enum logic [7:0] {
      M_IDLE       = 8'b0000_0001,
      M_COMMENT    = 8'b0000_0010,
      M_WORD       = 8'b0000_0100,
      M_NUMBER     = 8'b0000_1000,
      M_OPER       = 8'b0001_0000,
      M_STRING     = 8'b0010_0000,
      M_INCL_SPACE = 8'b0100_0000,
      M_INCL_NAME  = 8'b1000_0000
   } mode_type;

   // classified byte, passed from the front to the back through the queue
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_stream;
      logic       is_digit;
      logic       is_idc;
      logic       is_alpha;
      logic       is_space;
   } class_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [2:0]  detail;
      logic [23:0] value_start;
      logic [23:0] value_length;
      logic [15:0] line;
      logic [15:0] column;
      logic        last_of_run;
   } token_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [2:0] detail;
   } kw_type;

   // keyword lookup on the packed word, first byte lowest
   function automatic kw_type kw_lookup(input logic [63:0] w);
      kw_type r;
      r.kind   = K_ID;
      r.detail = 3'd0;
      unique case (w)
         64'h0000_0000_0072_6176: r.kind = K_VAR;
         64'h0000_0000_0000_6669: r.kind = K_IF;
         64'h0000_0000_6573_6C65: r.kind = K_ELSE;
         64'h6E6F_6974_636E_7566: r.kind = K_FUNC;
         64'h0000_6E72_7574_6572: r.kind = K_RETURN;
         64'h0000_0000_0072_6F66: r.kind = K_FOR;
         64'h0000_0065_6C69_6877: r.kind = K_WHILE;
         64'h0000_0000_0064_6E61: r.kind = K_ANDOR;
         64'h0000_0000_0000_726F: begin
            r.kind   = K_ANDOR;
            r.detail = 3'd1;
         end
         64'h0000_0000_0074_6F6E: r.kind = K_NOT;
         64'h0000_0000_006C_696E: r.kind = K_NIL;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] incl_char(input logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0: c = 8'h69;
         3'd1: c = 8'h6E;
         3'd2: c = 8'h63;
         3'd3: c = 8'h6C;
         3'd4: c = 8'h75;
         3'd5: c = 8'h64;
         3'd6: c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[hdl/slt_req_if.sv]
//------------------------------------------------------------------------------
// slt_req_if
// Byte channel: valid, ready and one source byte with end-of-stream flag.
//------------------------------------------------------------------------------
interface slt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_stream;
   modport source (output valid, text_byte, end_of_stream, input ready);
   modport sink   (input valid, text_byte, end_of_stream, output ready);
endinterface

[hdl/slt_rsp_if.sv]
//------------------------------------------------------------------------------
// slt_rsp_if
// Token channel: valid, ready and one token.
//------------------------------------------------------------------------------
interface slt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [2:0]  detail;
   logic [23:0] value_start;
   logic [23:0] value_length;
   logic [15:0] line;
   logic [15:0] column;
   logic        last_of_run;
   modport source (output valid, token_kind, detail, value_start, value_length, line,
                   column, last_of_run, input ready);
   modport sink   (input valid, token_kind, detail, value_start, value_length, line,
                   column, last_of_run, output ready);
endinterface

[hdl/slt_front.sv]
//------------------------------------------------------------------------------
// slt_front
// Register incoming bytes with their character classes into a 2-entry queue.
//------------------------------------------------------------------------------
module slt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_end_of_stream,
   output logic                 q_valid,
   input  logic                 q_pop,
   output slt_pkg::class_type   q_data
);
   slt_pkg::class_type mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   slt_pkg::class_type c;

   always_comb begin
      c.text_byte     = req_text_byte;
      c.end_of_stream = req_end_of_stream;
      c.is_digit      = (req_text_byte >= 8'h30) && (req_text_byte <= 8'h39);
      c.is_alpha      = ((req_text_byte >= 8'h61) && (req_text_byte <= 8'h7A)) ||
                        ((req_text_byte >= 8'h41) && (req_text_byte <= 8'h5A));
      c.is_idc        = c.is_alpha || c.is_digit || (req_text_byte == 8'h5F);
      c.is_space      = (req_text_byte == 8'h20) || (req_text_byte == 8'h09) ||
                        (req_text_byte == 8'h0D);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in  = rd_ff ^ q_pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) mem_ff[wr_ff] <= c;
   end
endmodule

[hdl/slt_back.sv]
//------------------------------------------------------------------------------
// slt_back
// Run the lexer state machine on one classified byte per cycle while two
// output queue entries are free, and hold up to four tokens in that queue.
//------------------------------------------------------------------------------
module slt_back #(
   parameter int unsigned OFFSET_BITS   = 24,
   parameter int unsigned LINE_BITS     = 16,
   parameter int unsigned KEYWORD_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  slt_pkg::class_type q_data,
   output logic               tok_valid,
   input  logic               tok_ready,
   output slt_pkg::token_type tok_data
);
   localparam logic [LINE_BITS-1:0] CNT_TOP = {LINE_BITS{1'b1}};

   slt_pkg::mode_type      mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in, ofs_ff, ofs_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, col_ff, col_in;
   logic [63:0]            word_ff, word_in;
   logic [2:0]             incl_ff, incl_in;
   logic                   quote_ff, quote_in;
   logic [7:0]             pend_ff, pend_in;
   logic                   halt_ff, halt_in;

   // output queue, four entries
   slt_pkg::token_type     oq_ff [4];
   logic [2:0]             ocnt_ff;
   logic [1:0]             ord_ff, owr_ff;

   slt_pkg::token_type     t0, t1;
   logic [1:0]             n;

   logic [7:0]             b;
   logic                   eos, redo, ws;
   logic [OFFSET_BITS-1:0] pos, pos1, len;
   logic [7:0]             q;
   slt_pkg::kw_type        kw;
   logic [4:0]             simple;
   logic                   have_simple;

   assign b   = q_data.text_byte;
   assign eos = q_data.end_of_stream;
   assign q_pop = q_valid && (ocnt_ff <= 3'd2);

   function automatic logic [23:0] ow(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+23:0] x;
      x = {24'd0, v};
      return x[23:0];
   endfunction

   function automatic logic [15:0] lw(input logic [LINE_BITS-1:0] v);
      logic [LINE_BITS+15:0] x;
      x = {16'd0, v};
      return x[15:0];
   endfunction

   always_comb begin
      logic [LINE_BITS-1:0] cc;
      logic [OFFSET_BITS-1:0] wl;
      slt_pkg::token_type tk;
      mode_in  = mode_ff;
      start_in = start_ff;
      ofs_in   = ofs_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      word_in  = word_ff;
      incl_in  = incl_ff;
      quote_in = quote_ff;
      pend_in  = pend_ff;
      halt_in  = halt_ff;
      n        = 2'd0;
      t0       = '0;
      t1       = '0;
      redo     = 1'b0;
      ws       = 1'b0;
      simple   = slt_pkg::K_ID;
      have_simple = 1'b0;
      kw       = '0;
      cc       = '0;
      wl       = '0;
      tk       = '0;
      pos      = ofs_ff;
      pos1     = ofs_ff + 1'b1;
      len      = pos - start_ff;
      q        = quote_ff ? 8'h22 : 8'h27;

      if (q_pop) begin
         if (!halt_ff) begin
            unique case (mode_ff)
               slt_pkg::M_COMMENT: begin
                  if (b == 8'h0A) begin
                     if (line_in < CNT_TOP) line_in = line_in + 1'b1;
                     col_in  = '0;
                     mode_in = slt_pkg::M_IDLE;
                  end else if (col_in < CNT_TOP) col_in = col_in + 1'b1;
               end
               slt_pkg::M_WORD: begin
                  if (q_data.is_idc) begin
                     if (len < OFFSET_BITS'(KEYWORD_BYTES))
                        word_in = word_ff | ({56'd0, b} << {len[2:0], 3'b000});
                     if ((len < OFFSET_BITS'(7)) && (len[2:0] == incl_ff) &&
                         (b == slt_pkg::incl_char(incl_ff))) begin
                        incl_in = incl_ff + 1'b1;
                        if (incl_ff == 3'd6) mode_in = slt_pkg::M_INCL_SPACE;
                     end
                     if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                  end else begin
                     kw = (len <= OFFSET_BITS'(KEYWORD_BYTES)) ?
                          slt_pkg::kw_lookup(word_ff) : '0;
                     tk.token_kind   = kw.kind;
                     tk.detail       = kw.detail;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = ow(len);
                     cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                     tk.line = lw(line_in);
                     tk.column = lw(cc);
                     t0 = tk; n = 2'd1;
                     mode_in = slt_pkg::M_IDLE;
                     redo = 1'b1;
                  end
               end
               slt_pkg::M_NUMBER: begin
                  if (q_data.is_digit || (b == 8'h2E)) begin
                     if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                  end else begin
                     tk.token_kind   = slt_pkg::K_NUMBER;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = ow(len);
                     cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                     tk.line = lw(line_in);
                     tk.column = lw(cc);
                     t0 = tk; n = 2'd1;
                     mode_in = slt_pkg::M_IDLE;
                     redo = 1'b1;
                  end
               end
               slt_pkg::M_OPER: begin
                  mode_in = slt_pkg::M_IDLE;
                  if (b == 8'h3D) begin
                     if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                     tk.token_kind = slt_pkg::K_CMP;
                     tk.detail = (pend_ff == 8'h3D) ? slt_pkg::C_EQ :
                                 (pend_ff == 8'h21) ? slt_pkg::C_NE :
                                 (pend_ff == 8'h3C) ? slt_pkg::C_LE : slt_pkg::C_GE;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = 24'd2;
                  end else if (pend_ff == 8'h3D) begin
                     tk.token_kind = slt_pkg::K_ASSIGN;
                     redo = 1'b1;
                  end else if (pend_ff == 8'h21) begin
                     tk.token_kind = slt_pkg::K_ERROR;
                     tk.detail = slt_pkg::E_BANG;
                     halt_in = 1'b1;
                  end else begin
                     tk.token_kind = slt_pkg::K_CMP;
                     tk.detail = (pend_ff == 8'h3C) ? slt_pkg::C_LT : slt_pkg::C_GT;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = 24'd1;
                     redo = 1'b1;
                  end
                  cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                  tk.line = lw(line_in);
                  tk.column = lw(cc);
                  t0 = tk; n = 2'd1;
               end
               slt_pkg::M_STRING: begin
                  if (b == q) begin
                     if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                     tk.token_kind   = slt_pkg::K_STRING;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = ow(len);
                     cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                     tk.line = lw(line_in);
                     tk.column = lw(cc);
                     t0 = tk; n = 2'd1;
                     mode_in = slt_pkg::M_IDLE;
                  end else if (b == 8'h0A) begin
                     if (line_in < CNT_TOP) line_in = line_in + 1'b1;
                     col_in = '0;
                  end else if (col_in < CNT_TOP) col_in = col_in + 1'b1;
               end
               slt_pkg::M_INCL_SPACE: begin
                  if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                  if ((b == 8'h27) || (b == 8'h22)) begin
                     quote_in = (b == 8'h22);
                     start_in = pos1;
                     mode_in  = slt_pkg::M_INCL_NAME;
                  end else if (!q_data.is_space) begin
                     cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                     tk.token_kind = slt_pkg::K_ERROR;
                     tk.detail = slt_pkg::E_NO_QUOTE;
                     tk.line = lw(line_in);
                     tk.column = lw(cc);
                     t0 = tk; n = 2'd1;
                     halt_in = 1'b1;
                     mode_in = slt_pkg::M_IDLE;
                  end
               end
               slt_pkg::M_INCL_NAME: begin
                  if (col_in < CNT_TOP) col_in = col_in + 1'b1;
                  cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
                  tk.line = lw(line_in);
                  tk.column = lw(cc);
                  if (b == q) begin
                     tk.token_kind   = slt_pkg::K_INCLUDE;
                     tk.value_start  = ow(start_ff);
                     tk.value_length = ow(len);
                     t0 = tk; n = 2'd1;
                     mode_in = slt_pkg::M_IDLE;
                  end else if (b == 8'h0A) begin
                     tk.token_kind = slt_pkg::K_ERROR;
                     tk.detail = slt_pkg::E_INCL_OPEN;
                     t0 = tk; n = 2'd1;
                     halt_in = 1'b1;
                     mode_in = slt_pkg::M_IDLE;
                  end
               end
               default: redo = 1'b1;
            endcase

            if (redo) begin
               // idle handling of this byte
               tk = '0;
               ws = 1'b0;
               if (col_in < CNT_TOP) col_in = col_in + 1'b1;
               cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
               tk.line = lw(line_in);
               tk.column = lw(cc);
               mode_in = slt_pkg::M_IDLE;
               if (q_data.is_space) begin
                  ws = 1'b0;
               end else begin
                  unique case (b)
                     8'h23: mode_in = slt_pkg::M_COMMENT;
                     8'h0A: begin
                        tk.token_kind = slt_pkg::K_STATEND; ws = 1'b1;
                        if (line_in < CNT_TOP) line_in = line_in + 1'b1;
                        col_in = '0;
                     end
                     8'h3B: begin simple = slt_pkg::K_STATEND; have_simple = 1'b1; end
                     8'h7B: begin simple = slt_pkg::K_LBRACE; have_simple = 1'b1; end
                     8'h7D: begin simple = slt_pkg::K_RBRACE; have_simple = 1'b1; end
                     8'h28: begin simple = slt_pkg::K_LPAREN; have_simple = 1'b1; end
                     8'h29: begin simple = slt_pkg::K_RPAREN; have_simple = 1'b1; end
                     8'h5B: begin simple = slt_pkg::K_LBRACK; have_simple = 1'b1; end
                     8'h5D: begin simple = slt_pkg::K_RBRACK; have_simple = 1'b1; end
                     8'h2C: begin simple = slt_pkg::K_COMMA; have_simple = 1'b1; end
                     8'h2E: begin simple = slt_pkg::K_DOT; have_simple = 1'b1; end
                     8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E: begin
                        tk.token_kind = (b == 8'h2B || b == 8'h2D) ? slt_pkg::K_ADDSUB :
                                        (b == 8'h2A || b == 8'h2F) ? slt_pkg::K_MULDIV :
                                        (b == 8'h25) ? slt_pkg::K_MOD : slt_pkg::K_POW;
                        tk.detail = {2'b00, (b == 8'h2D) || (b == 8'h2F)};
                        tk.value_start  = ow(pos);
                        tk.value_length = 24'd1;
                        ws = 1'b1;
                     end
                     8'h3D, 8'h21, 8'h3C, 8'h3E: begin
                        pend_in  = b;
                        start_in = pos;
                        mode_in  = slt_pkg::M_OPER;
                     end
                     8'h27, 8'h22: begin
                        quote_in = (b == 8'h22);
                        start_in = pos1;
                        mode_in  = slt_pkg::M_STRING;
                     end
                     default: begin
                        if (q_data.is_digit) begin
                           start_in = pos;
                           mode_in  = slt_pkg::M_NUMBER;
                        end else if (q_data.is_alpha) begin
                           start_in = pos;
                           word_in  = {56'd0, b};
                           incl_in  = (b == 8'h69) ? 3'd1 : 3'd0;
                           mode_in  = slt_pkg::M_WORD;
                        end else begin
                           tk.token_kind = slt_pkg::K_ERROR;
                           tk.detail = slt_pkg::E_UNKNOWN;
                           ws = 1'b1;
                           halt_in = 1'b1;
                        end
                     end
                  endcase
                  if (have_simple) begin
                     tk.token_kind = simple;
                     ws = 1'b1;
                  end
               end
               if (ws) begin
                  if (n == 2'd0) begin t0 = tk; n = 2'd1; end
                  else begin t1 = tk; n = 2'd2; end
               end
            end
         end

         if (eos) begin
            if (!halt_in) begin
               wl = pos1 - start_in;
               tk = '0;
               cc = (col_in < CNT_TOP) ? col_in + 1'b1 : col_in;
               tk.line = lw(line_in);
               tk.column = lw(cc);
               ws = 1'b1;
               unique case (mode_in)
                  slt_pkg::M_WORD: begin
                     kw = (wl <= OFFSET_BITS'(KEYWORD_BYTES)) ?
                          slt_pkg::kw_lookup(word_in) : '0;
                     tk.token_kind = kw.kind;
                     tk.detail = kw.detail;
                     tk.value_start = ow(start_in);
                     tk.value_length = ow(wl);
                  end
                  slt_pkg::M_NUMBER: begin
                     tk.token_kind = slt_pkg::K_NUMBER;
                     tk.value_start = ow(start_in);
                     tk.value_length = ow(wl);
                  end
                  slt_pkg::M_OPER: begin
                     if (pend_in == 8'h3D) tk.token_kind = slt_pkg::K_ASSIGN;
                     else if (pend_in == 8'h21) begin
                        tk.token_kind = slt_pkg::K_ERROR;
                        tk.detail = slt_pkg::E_BANG;
                     end else begin
                        tk.token_kind = slt_pkg::K_CMP;
                        tk.detail = (pend_in == 8'h3C) ? slt_pkg::C_LT : slt_pkg::C_GT;
                        tk.value_start = ow(start_in);
                        tk.value_length = 24'd1;
                     end
                  end
                  slt_pkg::M_STRING: begin
                     tk.token_kind = slt_pkg::K_ERROR; tk.detail = slt_pkg::E_STR_OPEN;
                  end
                  slt_pkg::M_INCL_SPACE: begin
                     tk.token_kind = slt_pkg::K_ERROR; tk.detail = slt_pkg::E_NO_QUOTE;
                  end
                  slt_pkg::M_INCL_NAME: begin
                     tk.token_kind = slt_pkg::K_ERROR; tk.detail = slt_pkg::E_INCL_OPEN;
                  end
                  default: ws = 1'b0;
               endcase
               if (ws && (n != 2'd2)) begin
                  if (n == 2'd0) begin t0 = tk; n = 2'd1; end
                  else begin t1 = tk; n = 2'd2; end
               end
            end
            mode_in  = slt_pkg::M_IDLE;
            start_in = '0;
            ofs_in   = '0;
            line_in  = {{(LINE_BITS-1){1'b0}}, 1'b1};
            col_in   = '0;
            word_in  = '0;
            incl_in  = '0;
            quote_in = 1'b0;
            pend_in  = '0;
            halt_in  = 1'b0;
         end else begin
            ofs_in = pos1;
         end
         if (n == 2'd1) t0.last_of_run = 1'b1;
         if (n == 2'd2) t1.last_of_run = 1'b1;
      end
   end

   assign tok_valid = (ocnt_ff != 3'd0);
   assign tok_data  = oq_ff[ord_ff];

   always_ff @(posedge clock) begin
      logic pop;
      pop = tok_valid && tok_ready;
      if (reset) begin
         mode_ff  <= slt_pkg::M_IDLE;
         start_ff <= '0;
         ofs_ff   <= '0;
         line_ff  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff   <= '0;
         word_ff  <= '0;
         incl_ff  <= '0;
         quote_ff <= 1'b0;
         pend_ff  <= '0;
         halt_ff  <= 1'b0;
         ocnt_ff  <= '0;
         ord_ff   <= '0;
         owr_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         ofs_ff   <= ofs_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         word_ff  <= word_in;
         incl_ff  <= incl_in;
         quote_ff <= quote_in;
         pend_ff  <= pend_in;
         halt_ff  <= halt_in;
         ocnt_ff  <= ocnt_ff + {1'b0, n} - {2'b00, pop};
         ord_ff   <= ord_ff + {1'b0, pop};
         owr_ff   <= owr_ff + n;
      end
      if (n != 2'd0) oq_ff[owr_ff] <= t0;
      if (n == 2'd2) oq_ff[owr_ff + 2'd1] <= t1;
   end
endmodule

[hdl/script_language_tokenizer.sv]
//------------------------------------------------------------------------------
// script_language_tokenizer
// Streaming tokenizer: one source byte in, zero to two tokens out.
// Path: a byte is registered in the front queue, and its tokens then in the
// output queue of slt_back, which drives rsp. Throughput: one byte per cycle
// while two output queue entries are free; tokens leave one per rsp transfer.
// Reset: synchronous; clears queues and lexer state to line 1, offset 0.
//------------------------------------------------------------------------------
module script_language_tokenizer #(
   parameter int unsigned OFFSET_BITS   = 24,
   parameter int unsigned LINE_BITS     = 16,
   parameter int unsigned KEYWORD_BYTES = 8
) (
   input  logic     clock,
   input  logic     reset,
   slt_req_if.sink  req,
   slt_rsp_if.source rsp
);
   logic               q_valid, q_pop;
   slt_pkg::class_type q_data;
   slt_pkg::token_type tok;

   slt_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_text_byte(req.text_byte), .req_end_of_stream(req.end_of_stream),
      .q_valid, .q_pop, .q_data
   );

   slt_back #(
      .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .KEYWORD_BYTES(KEYWORD_BYTES)
   ) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .tok_valid(rsp.valid), .tok_ready(rsp.ready), .tok_data(tok)
   );

   assign rsp.token_kind   = tok.token_kind;
   assign rsp.detail       = tok.detail;
   assign rsp.value_start  = tok.value_start;
   assign rsp.value_length = tok.value_length;
   assign rsp.line         = tok.line;
   assign rsp.column       = tok.column;
   assign rsp.last_of_run  = tok.last_of_run;
endmodule

[tb/sv/script_language_tokenizer_test.sv]
//------------------------------------------------------------------------------
// script_language_tokenizer_test
// Streams source text into the tokenizer and checks every token it emits
// against a behavioral lexer kept in the test, with random gaps on both sides.
//------------------------------------------------------------------------------
module script_language_tokenizer_test;

   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slt_req_if req ();
   slt_rsp_if rsp ();

   script_language_tokenizer dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   // lexer state of the prediction
   typedef enum logic [3:0] {
      L_IDLE, L_COMMENT, L_WORD, L_NUMBER, L_OPER, L_STRING, L_INCL_SPACE, L_INCL_NAME
   } lex_state_type;

   lex_state_type lx_mode;
   logic [23:0]   lx_start;
   logic [23:0]   lx_offset;
   logic [15:0]   lx_line;
   logic [15:0]   lx_column;
   logic [63:0]   lx_prefix;
   logic [2:0]    lx_incl;
   logic          lx_dquote;
   logic [7:0]    lx_pending;
   logic          lx_halted;

   slt_pkg::token_type   token_queue[$];
   slt_pkg::token_type   step_tokens[$];
   int          failures = 0;
   int          idle_count = 0;
   bit          gaps_on = 1'b1;
   bit          done = 1'b0;

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_space(logic [7:0] b);
      return b == " " || b == 8'h09 || b == 8'h0D;
   endfunction

   function automatic logic [7:0] include_byte(int i);
      string s;
      s = "include";
      return s[i];
   endfunction

   task automatic lexer_reset();
      lx_mode = L_IDLE;
      lx_start = '0;
      lx_offset = '0;
      lx_line = 16'd1;
      lx_column = '0;
      lx_prefix = '0;
      lx_incl = '0;
      lx_dquote = 1'b0;
      lx_pending = '0;
      lx_halted = 1'b0;
   endtask

   task automatic advance_column();
      if (lx_column != 16'hFFFF) lx_column++;
   endtask

   task automatic advance_line();
      if (lx_line != 16'hFFFF) lx_line++;
      lx_column = '0;
   endtask

   task automatic emit(logic [4:0] kind, logic [2:0] det, logic [23:0] st, logic [23:0] len);
      slt_pkg::token_type t;
      t.token_kind = kind;
      t.detail = det;
      t.value_start = st;
      t.value_length = len;
      t.line = lx_line;
      t.column = (lx_column == 16'hFFFF) ? 16'hFFFF : lx_column + 16'd1;
      t.last_of_run = 1'b0;
      if (step_tokens.size() < 2) step_tokens.push_back(t);
   endtask

   task automatic raise_error(logic [2:0] code);
      emit(slt_pkg::K_ERROR, code, '0, '0);
      lx_halted = 1'b1;
      lx_mode = L_IDLE;
   endtask

   task automatic close_word(logic [23:0] end_pos);
      logic [23:0] len;
      logic [4:0]  kind;
      logic [2:0]  det;
      len = end_pos - lx_start;
      kind = slt_pkg::K_ID;
      det = '0;
      if (len <= 8) begin
         case (lx_prefix)
            "rav":      kind = slt_pkg::K_VAR;
            "fi":       kind = slt_pkg::K_IF;
            "esle":     kind = slt_pkg::K_ELSE;
            "noitcnuf": kind = slt_pkg::K_FUNC;
            "nruter":   kind = slt_pkg::K_RETURN;
            "rof":      kind = slt_pkg::K_FOR;
            "elihw":    kind = slt_pkg::K_WHILE;
            "dna":      kind = slt_pkg::K_ANDOR;
            "ro": begin
               kind = slt_pkg::K_ANDOR;
               det = 3'd1;
            end
            "ton":      kind = slt_pkg::K_NOT;
            "lin":      kind = slt_pkg::K_NIL;
            default: ;
         endcase
      end
      emit(kind, det, lx_start, len);
      lx_mode = L_IDLE;
   endtask

   task automatic close_operator(bit with_eq);
      lx_mode = L_IDLE;
      if (with_eq) begin
         emit(slt_pkg::K_CMP, lx_pending == "=" ? slt_pkg::C_EQ :
              lx_pending == "!" ? slt_pkg::C_NE :
              lx_pending == "<" ? slt_pkg::C_LE : slt_pkg::C_GE, lx_start, 24'd2);
      end else if (lx_pending == "=") begin
         emit(slt_pkg::K_ASSIGN, '0, '0, '0);
      end else if (lx_pending == "!") begin
         raise_error(slt_pkg::E_BANG);
      end else begin
         emit(slt_pkg::K_CMP, lx_pending == "<" ? slt_pkg::C_LT : slt_pkg::C_GT,
              lx_start, 24'd1);
      end
   endtask

   task automatic start_byte(logic [7:0] b, logic [23:0] pos);
      advance_column();
      if (is_space(b)) return;
      case (b)
         "#": lx_mode = L_COMMENT;
         8'h0A: begin
            emit(slt_pkg::K_STATEND, '0, '0, '0);
            advance_line();
         end
         ";": emit(slt_pkg::K_STATEND, '0, '0, '0);
         "{": emit(slt_pkg::K_LBRACE, '0, '0, '0);
         "}": emit(slt_pkg::K_RBRACE, '0, '0, '0);
         "(": emit(slt_pkg::K_LPAREN, '0, '0, '0);
         ")": emit(slt_pkg::K_RPAREN, '0, '0, '0);
         "[": emit(slt_pkg::K_LBRACK, '0, '0, '0);
         "]": emit(slt_pkg::K_RBRACK, '0, '0, '0);
         ",": emit(slt_pkg::K_COMMA, '0, '0, '0);
         ".": emit(slt_pkg::K_DOT, '0, '0, '0);
         "+": emit(slt_pkg::K_ADDSUB, 3'd0, pos, 24'd1);
         "-": emit(slt_pkg::K_ADDSUB, 3'd1, pos, 24'd1);
         "*": emit(slt_pkg::K_MULDIV, 3'd0, pos, 24'd1);
         "/": emit(slt_pkg::K_MULDIV, 3'd1, pos, 24'd1);
         "%": emit(slt_pkg::K_MOD, '0, pos, 24'd1);
         "^": emit(slt_pkg::K_POW, '0, pos, 24'd1);
         "=", "!", "<", ">": begin
            lx_pending = b;
            lx_start = pos;
            lx_mode = L_OPER;
         end
         "'", "\"": begin
            lx_dquote = (b == "\"");
            lx_start = pos + 24'd1;
            lx_mode = L_STRING;
         end
         default: begin
            if (is_digit(b)) begin
               lx_start = pos;
               lx_mode = L_NUMBER;
            end else if (is_alpha(b)) begin
               lx_start = pos;
               lx_prefix = {56'd0, b};
               lx_incl = (b == "i") ? 3'd1 : 3'd0;
               lx_mode = L_WORD;
            end else begin
               raise_error(slt_pkg::E_UNKNOWN);
            end
         end
      endcase
   endtask

   // predict the tokens of one byte and queue them
   task automatic predict_tokens(logic [7:0] b, logic eos);
      logic [23:0] pos;
      logic [23:0] len;
      logic [7:0]  q;
      bit          redo;
      pos = lx_offset;
      redo = 1'b0;
      step_tokens.delete();
      if (!lx_halted) begin
         q = lx_dquote ? "\"" : "'";
         case (lx_mode)
            L_COMMENT:
               if (b == 8'h0A) begin
                  advance_line();
                  lx_mode = L_IDLE;
               end else advance_column();
            L_WORD:
               if (is_alpha(b) || is_digit(b) || b == "_") begin
                  len = pos - lx_start;
                  if (len < 8) lx_prefix |= 64'(b) << (8 * len);
                  if (24'(lx_incl) == len && len < 7 && b == include_byte(len)) begin
                     lx_incl++;
                     if (lx_incl == 3'd7) lx_mode = L_INCL_SPACE;
                  end
                  advance_column();
               end else begin
                  close_word(pos);
                  redo = 1'b1;
               end
            L_NUMBER:
               if (is_digit(b) || b == ".") advance_column();
               else begin
                  emit(slt_pkg::K_NUMBER, '0, lx_start, pos - lx_start);
                  lx_mode = L_IDLE;
                  redo = 1'b1;
               end
            L_OPER:
               if (b == "=") begin
                  advance_column();
                  close_operator(1'b1);
               end else begin
                  close_operator(1'b0);
                  redo = !lx_halted;
               end
            L_STRING:
               if (b == q) begin
                  advance_column();
                  emit(slt_pkg::K_STRING, '0, lx_start, pos - lx_start);
                  lx_mode = L_IDLE;
               end else if (b == 8'h0A) advance_line();
               else advance_column();
            L_INCL_SPACE: begin
               advance_column();
               if (b == "'" || b == "\"") begin
                  lx_dquote = (b == "\"");
                  lx_start = pos + 24'd1;
                  lx_mode = L_INCL_NAME;
               end else if (!is_space(b)) raise_error(slt_pkg::E_NO_QUOTE);
            end
            L_INCL_NAME: begin
               advance_column();
               if (b == q) begin
                  emit(slt_pkg::K_INCLUDE, '0, lx_start, pos - lx_start);
                  lx_mode = L_IDLE;
               end else if (b == 8'h0A) raise_error(slt_pkg::E_INCL_OPEN);
            end
            default: redo = 1'b1;
         endcase
         if (redo) start_byte(b, pos);
      end
      if (eos) begin
         if (!lx_halted) begin
            case (lx_mode)
               L_WORD: close_word(pos + 24'd1);
               L_NUMBER: emit(slt_pkg::K_NUMBER, '0, lx_start, pos + 24'd1 - lx_start);
               L_OPER: close_operator(1'b0);
               L_STRING: raise_error(slt_pkg::E_STR_OPEN);
               L_INCL_SPACE: raise_error(slt_pkg::E_NO_QUOTE);
               L_INCL_NAME: raise_error(slt_pkg::E_INCL_OPEN);
               default: ;
            endcase
         end
         lexer_reset();
      end else begin
         lx_offset = pos + 24'd1;
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
   endtask

   // valid stays high after a transfer until the next byte, a gap or a drain
   task automatic send_byte(logic [7:0] b, logic eos);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.text_byte <= b;
      req.end_of_stream <= eos;
      do @(posedge clock); while (!req.ready);
      predict_tokens(b, eos);
   endtask

   task automatic send_text(string s, bit eos);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && i == s.len() - 1);
   endtask

   task automatic drain_tokens();
      req.valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_symbols();
      send_text("var x = 10.5; y==z != a <= b >= c < d > e\n", 1'b0);
      send_text("{ } ( ) [ ] , . + - * / % ^ \t\r # note ;\n", 1'b1);
   endtask

   task automatic test_keywords();
      send_text("if else function return for while and or not nil var_x ", 1'b0);
      send_text("functions a_1 Zz 'it''s\nok' \"q\" 42", 1'b1);
   endtask

   task automatic test_include();
      send_text("include  \"lib.s\"\nxinclude 'a'\nincludeme\"b\"", 1'b1);
      send_text("include x", 1'b1);
      send_text("include 'abc\nzz", 1'b1);
      send_text("include", 1'b1);
      send_text("include \"q", 1'b1);
   endtask

   task automatic test_errors();
      send_text("a!b c", 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_text("\"open", 1'b1);
      send_text("abc", 1'b1);
      send_text("!", 1'b1);
      send_text("<", 1'b1);
      send_text("7", 1'b1);
   endtask

   task automatic test_random_text();
      string pieces[24] = '{"var", "if", "else", "function", "return", "for", "while",
         "and", "or", "not", "nil", "include \"f\"", "abc_9", "12.3", "'s t'",
         "\"m\nl\"", "==", "<=", ">", "!=", "=", "#c\n", "\n", ";"};
      string seps[4] = '{" ", "\t", "", "+"};
      int sent;
      sent = 0;
      drain_tokens();
      while (sent < 320) begin
         if (sent > 240) gaps_on = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
            sent++;
         end else begin
            string p;
            p = {pieces[$urandom_range(0, 23)], seps[$urandom_range(0, 3)]};
            send_text(p, $urandom_range(0, 15) == 0);
            sent += p.len();
         end
      end
      send_byte("x", 1'b1);
   endtask

   // token side: random stalls and comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (token_queue.size() == 0) begin
               $error("unexpected token kind %0d", rsp.token_kind);
               failures++;
            end else begin
               slt_pkg::token_type e;
               e = token_queue.pop_front();
               if (rsp.token_kind !== e.token_kind) begin
                  $error("token_kind expected %0d actual %0d", e.token_kind, rsp.token_kind);
                  failures++;
               end
               if (rsp.detail !== e.detail) begin
                  $error("detail expected %0d actual %0d", e.detail, rsp.detail);
                  failures++;
               end
               if (rsp.value_start !== e.value_start) begin
                  $error("value_start expected %0d actual %0d", e.value_start,
                         rsp.value_start);
                  failures++;
               end
               if (rsp.value_length !== e.value_length) begin
                  $error("value_length expected %0d actual %0d", e.value_length,
                         rsp.value_length);
                  failures++;
               end
               if (rsp.line !== e.line) begin
                  $error("line expected %0d actual %0d", e.line, rsp.line);
                  failures++;
               end
               if (rsp.column !== e.column) begin
                  $error("column expected %0d actual %0d", e.column, rsp.column);
                  failures++;
               end
               if (rsp.last_of_run !== e.last_of_run) begin
                  $error("last_of_run expected %0d actual %0d", e.last_of_run,
                         rsp.last_of_run);
                  failures++;
               end
            end
         end
         if (idle_count > 0) begin
            idle_count <= idle_count - 1;
            rsp.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            idle_count <= $urandom_range(1, 15) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset || done)
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT && (req.valid || token_queue.size() != 0)) begin
         $display("script_language_tokenizer regression: fail");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.text_byte = '0;
      req.end_of_stream = 1'b0;
      rsp.ready = 1'b0;
      lexer_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_symbols();
      test_keywords();
      test_include();
      test_errors();
      test_random_text();
      drain_tokens();
      done = 1'b1;
      if (failures == 0) $display("script_language_tokenizer regression: pass");
      else $display("script_language_tokenizer regression: fail");
      $finish;
   end

endmodule

[filelist.f]
hdl/slt_pkg.sv
hdl/slt_req_if.sv
hdl/slt_rsp_if.sv
hdl/slt_front.sv
hdl/slt_back.sv
hdl/script_language_tokenizer.sv
tb/sv/script_language_tokenizer_test.sv
